/* rtl/wav_stream_parser_mono_downmix_core_macros.svh */
// Assertion helpers for the WAV parser core.
`ifndef WAV_STREAM_PARSER_MONO_DOWNMIX_CORE_MACROS_SVH
`define WAV_STREAM_PARSER_MONO_DOWNMIX_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Consequent holds in the same cycle as the antecedent.
`define WSPMD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Consequent holds in the cycle after the antecedent.
`define WSPMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define WSPMD_ASSERT_SAME(label, clk, rst, ante, cons)
`define WSPMD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/wspmd_pkg.sv */
`default_nettype none
package wspmd_pkg;

   typedef enum logic [2:0] {
      PH_RIFF, PH_HDR, PH_FMT, PH_SKIP, PH_DATA, PH_CONV, PH_DRAIN
   } phase_type;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_INFO   = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [3:0] ERR_MAGIC     = 4'd0;
   localparam logic [3:0] ERR_SHORT_FMT = 4'd1;
   localparam logic [3:0] ERR_TRUNC_FMT = 4'd2;
   localparam logic [3:0] ERR_TRUNC_DAT = 4'd3;
   localparam logic [3:0] ERR_MISSING   = 4'd4;
   localparam logic [3:0] ERR_CHANNELS  = 4'd5;
   localparam logic [3:0] ERR_ZERO_RATE = 4'd6;
   localparam logic [3:0] ERR_FORMAT    = 4'd7;
   localparam logic [3:0] ERR_FLT_BITS  = 4'd8;
   localparam logic [3:0] ERR_PCM_BITS  = 4'd9;
   localparam logic [3:0] ERR_DATA_SIZE = 4'd10;

   typedef struct packed {
      logic [3:0] idx;
      logic       tag_next_riff;
      logic       tag_next_wave;
      logic       tag_fmt;
      logic       tag_data;
      logic       left_next_lt16;
      logic       left_next_zero;
      logic       left_zero;
      logic       left_one;
      logic       hdr_err;
      logic [3:0] hdr_err_code;
      logic       sample_done;
      logic       stereo;
      logic       pos;
   } stat_type;

   typedef struct packed {
      logic       clear_all;
      logic       enter_hdr;
      logic       tag_shift;
      logic       left_hdr;
      logic       left_sub16;
      logic       left_dec;
      logic       idx_inc;
      logic       idx_clr;
      logic       fmt_cap;
      logic       fmt_seen_set;
      logic       gather_put;
      logic       gather_clr;
      logic       first_store;
      logic       pos_clr;
      logic       out_load;
      logic [1:0] out_kind;
      logic [3:0] out_err;
      logic       out_last;
   } cmd_type;

endpackage
`default_nettype wire

/* rtl/wspmd_if.sv */
`default_nettype none
interface wspmd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] file_byte;
   logic       final_byte;
   modport source (output valid, file_byte, final_byte, input ready);
   modport sink (input valid, file_byte, final_byte, output ready);
endinterface

interface wspmd_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         result_kind;
   logic signed [31:0] mono_sample;
   logic [31:0]        rate_hz;
   logic [1:0]         source_channels;
   logic [6:0]         sample_bits;
   logic [3:0]         error_code;
   logic               last_of_stream;
   modport source (output valid, result_kind, mono_sample, rate_hz, source_channels,
                   sample_bits, error_code, last_of_stream, input ready);
   modport sink (input valid, result_kind, mono_sample, rate_hz, source_channels,
                 sample_bits, error_code, last_of_stream, output ready);
endinterface
`default_nettype wire

/* rtl/wspmd_dp.sv */
`default_nettype none
module wspmd_dp (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [7:0]         file_byte,
   input  wspmd_pkg::cmd_type      cmd,
   output wspmd_pkg::stat_type     stat,
   output logic [1:0]              result_kind,
   output logic signed [31:0]      mono_sample,
   output logic [31:0]             rate_hz,
   output logic [1:0]              source_channels,
   output logic [6:0]              sample_bits,
   output logic [3:0]              error_code,
   output logic                    last_of_stream
);
   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;
   localparam logic [31:0] Q31_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0] Q31_MIN  = 32'h8000_0000;

   logic [31:0] tag_ff, tag_in, left_ff, left_in, left_hdr_val;
   logic [1:0]  res3_ff, res3_in, res3_next;
   logic [63:0] gather_ff, gather_in;
   logic [15:0] fmt_ff, fmt_in, ch_ff, ch_in, bits_ff, bits_in;
   logic [31:0] rate_ff, rate_in, first_ff, first_in;
   logic        seen_ff, seen_in, pos_ff, pos_in;
   logic [3:0]  idx_ff, idx_in;
   logic [31:0] conv, avg, smp;
   logic [3:0]  bps;
   logic        size_ok;
   logic [1:0]  kind_ff;
   logic [31:0] mono_ff, rate_o_ff;
   logic [1:0]  ch_o_ff;
   logic [6:0]  bits_o_ff;
   logic [3:0]  err_ff;
   logic        last_ff;

   // byte residue modulo 3 (256 is 1 modulo 3, so bytes add)
   function automatic logic [1:0] mod3_byte(input logic [7:0] b);
      logic [3:0] s;
      logic [2:0] t;
      s = 4'(b[1:0]) + 4'(b[3:2]) + 4'(b[5:4]) + 4'(b[7:6]);
      t = 3'(s[1:0]) + 3'(s[3:2]);
      if (t >= 3'd3) t = t - 3'd3;
      if (t >= 3'd3) t = t - 3'd3;
      return t[1:0];
   endfunction

   always_comb begin
      logic [2:0] r;
      tag_in       = {tag_ff[23:0], file_byte};
      left_hdr_val = left_ff | (32'(file_byte) << {idx_ff[1:0], 3'b000});
      r            = 3'(res3_ff) + 3'(mod3_byte(file_byte));
      if (r >= 3'd3) r = r - 3'd3;
      res3_next    = r[1:0];
   end

   always_comb begin
      bps = bits_ff[6:3];
      case (bps)
         4'd1:    size_ok = (ch_ff == 16'd1) || !left_hdr_val[0];
         4'd2:    size_ok = (ch_ff == 16'd1) ? !left_hdr_val[0] : (left_hdr_val[1:0] == 2'd0);
         4'd3:    size_ok = (res3_next == 2'd0) && ((ch_ff == 16'd1) || !left_hdr_val[0]);
         4'd4:    size_ok = (ch_ff == 16'd1) ? (left_hdr_val[1:0] == 2'd0)
                                             : (left_hdr_val[2:0] == 3'd0);
         default: size_ok = (ch_ff == 16'd1) ? (left_hdr_val[2:0] == 3'd0)
                                             : (left_hdr_val[3:0] == 4'd0);
      endcase
   end

   always_comb begin
      stat.idx            = idx_ff;
      stat.tag_next_riff  = (tag_in == TAG_RIFF);
      stat.tag_next_wave  = (tag_in == TAG_WAVE);
      stat.tag_fmt        = (tag_ff == TAG_FMT);
      stat.tag_data       = (tag_ff == TAG_DATA);
      stat.left_next_lt16 = (left_hdr_val < 32'd16);
      stat.left_next_zero = (left_hdr_val == 32'd0);
      stat.left_zero      = (left_ff == 32'd0);
      stat.left_one       = (left_ff == 32'd1);
      stat.sample_done    = ({1'b0, idx_ff} + 5'd1) >= {1'b0, bits_ff[6:3]};
      stat.stereo         = (ch_ff == 16'd2);
      stat.pos            = pos_ff;
      stat.hdr_err        = 1'b1;
      if (!seen_ff)                                  stat.hdr_err_code = wspmd_pkg::ERR_MISSING;
      else if (ch_ff != 16'd1 && ch_ff != 16'd2)     stat.hdr_err_code = wspmd_pkg::ERR_CHANNELS;
      else if (rate_ff == 32'd0)                     stat.hdr_err_code = wspmd_pkg::ERR_ZERO_RATE;
      else if (fmt_ff != 16'd1 && fmt_ff != 16'd3)   stat.hdr_err_code = wspmd_pkg::ERR_FORMAT;
      else if (fmt_ff == 16'd3 && bits_ff != 16'd32 && bits_ff != 16'd64)
         stat.hdr_err_code = wspmd_pkg::ERR_FLT_BITS;
      else if (fmt_ff == 16'd1 && bits_ff != 16'd8 && bits_ff != 16'd16 &&
               bits_ff != 16'd24 && bits_ff != 16'd32)
         stat.hdr_err_code = wspmd_pkg::ERR_PCM_BITS;
      else if (!size_ok)                             stat.hdr_err_code = wspmd_pkg::ERR_DATA_SIZE;
      else begin
         stat.hdr_err      = 1'b0;
         stat.hdr_err_code = wspmd_pkg::ERR_MAGIC;
      end
   end

   // sample to Q1.31; floats truncate toward zero, NaN gives zero
   always_comb begin
      logic        neg;
      logic [7:0]  e32;
      logic [10:0] e64;
      logic [30:0] mag;
      logic [52:0] sh64;
      neg  = 1'b0;
      mag  = 31'd0;
      e32  = gather_ff[30:23];
      e64  = gather_ff[62:52];
      sh64 = 53'd0;
      conv = 32'd0;
      if (fmt_ff == 16'd3) begin
         if (bits_ff == 16'd32) begin
            neg = gather_ff[31];
            if (e32 == 8'hFF)
               conv = (gather_ff[22:0] != 23'd0) ? 32'd0 : (neg ? Q31_MIN : Q31_MAX);
            else if (e32 >= 8'd127)
               conv = neg ? Q31_MIN : Q31_MAX;
            else begin
               if (e32 != 8'd0)
                  mag = {1'b1, gather_ff[22:0], 7'd0} >> (8'd126 - e32);
               conv = neg ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
            end
         end else begin
            neg = gather_ff[63];
            if (e64 == 11'h7FF)
               conv = (gather_ff[51:0] != 52'd0) ? 32'd0 : (neg ? Q31_MIN : Q31_MAX);
            else if (e64 >= 11'd1023)
               conv = neg ? Q31_MIN : Q31_MAX;
            else begin
               if (e64 != 11'd0) begin
                  sh64 = {1'b1, gather_ff[51:0]} >> (11'd1044 - e64);
                  mag  = sh64[30:0];
               end
               conv = neg ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
            end
         end
      end else begin
         case (bits_ff[6:0])
            7'd8:    conv = {gather_ff[7:0] ^ 8'h80, 24'd0};
            7'd16:   conv = {gather_ff[15:0], 16'd0};
            7'd24:   conv = {gather_ff[23:0], 8'd0};
            default: conv = gather_ff[31:0];
         endcase
      end
   end

   always_comb begin
      logic [32:0] s;
      s   = 33'(first_ff ^ Q31_MIN) + 33'(conv ^ Q31_MIN);
      avg = s[32:1] ^ Q31_MIN;
      smp = (stat.stereo && pos_ff) ? avg : conv;
   end

   always_comb begin
      left_in   = left_ff;
      if (cmd.left_hdr)
         left_in = cmd.left_sub16 ? (left_hdr_val - 32'd16) : left_hdr_val;
      else if (cmd.left_dec)
         left_in = left_ff - 32'd1;
      res3_in   = cmd.left_hdr ? res3_next : res3_ff;
      idx_in    = cmd.idx_clr ? 4'd0 : (cmd.idx_inc ? idx_ff + 4'd1 : idx_ff);
      gather_in = gather_ff;
      if (cmd.gather_clr)
         gather_in = 64'd0;
      else if (cmd.gather_put)
         gather_in[{idx_ff[2:0], 3'b000} +: 8] = file_byte;
      fmt_in  = fmt_ff;
      ch_in   = ch_ff;
      rate_in = rate_ff;
      bits_in = bits_ff;
      if (cmd.fmt_cap) begin
         case (idx_ff)
            4'd0:    fmt_in = {8'd0, file_byte};
            4'd1:    fmt_in[15:8] = file_byte;
            4'd2:    ch_in = {8'd0, file_byte};
            4'd3:    ch_in[15:8] = file_byte;
            4'd4:    rate_in = {24'd0, file_byte};
            4'd5:    rate_in[15:8] = file_byte;
            4'd6:    rate_in[23:16] = file_byte;
            4'd7:    rate_in[31:24] = file_byte;
            4'd14:   bits_in = {8'd0, file_byte};
            4'd15:   bits_in[15:8] = file_byte;
            default: ;
         endcase
      end
      seen_in  = seen_ff | cmd.fmt_seen_set;
      first_in = cmd.first_store ? conv : first_ff;
      pos_in   = cmd.first_store ? 1'b1 : (cmd.pos_clr ? 1'b0 : pos_ff);
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         tag_ff    <= '0;
         left_ff   <= '0;
         res3_ff   <= '0;
         idx_ff    <= '0;
         gather_ff <= '0;
         fmt_ff    <= '0;
         ch_ff     <= '0;
         rate_ff   <= '0;
         bits_ff   <= '0;
         seen_ff   <= 1'b0;
         first_ff  <= '0;
         pos_ff    <= 1'b0;
      end else begin
         if (cmd.enter_hdr) begin
            tag_ff  <= '0;
            left_ff <= '0;
            res3_ff <= '0;
            idx_ff  <= '0;
         end else begin
            if (cmd.tag_shift) tag_ff <= tag_in;
            left_ff <= left_in;
            res3_ff <= res3_in;
            idx_ff  <= idx_in;
         end
         gather_ff <= gather_in;
         fmt_ff    <= fmt_in;
         ch_ff     <= ch_in;
         rate_ff   <= rate_in;
         bits_ff   <= bits_in;
         seen_ff   <= seen_in;
         first_ff  <= first_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         kind_ff   <= cmd.out_kind;
         err_ff    <= (cmd.out_kind == wspmd_pkg::KIND_ERROR) ? cmd.out_err : 4'd0;
         last_ff   <= cmd.out_last;
         mono_ff   <= (cmd.out_kind == wspmd_pkg::KIND_SAMPLE) ? smp : 32'd0;
         rate_o_ff <= (cmd.out_kind == wspmd_pkg::KIND_INFO) ? rate_ff : 32'd0;
         ch_o_ff   <= (cmd.out_kind == wspmd_pkg::KIND_INFO) ? ch_ff[1:0] : 2'd0;
         bits_o_ff <= (cmd.out_kind == wspmd_pkg::KIND_INFO) ? bits_ff[6:0] : 7'd0;
      end
   end

   assign result_kind     = kind_ff;
   assign mono_sample     = mono_ff;
   assign rate_hz         = rate_o_ff;
   assign source_channels = ch_o_ff;
   assign sample_bits     = bits_o_ff;
   assign error_code      = err_ff;
   assign last_of_stream  = last_ff;
endmodule
`default_nettype wire

/* rtl/wspmd_ctrl.sv */
`default_nettype none
`include "wav_stream_parser_mono_downmix_core_macros.svh"
module wspmd_ctrl (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_final,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   input  wspmd_pkg::stat_type stat,
   output wspmd_pkg::cmd_type  cmd
);
   wspmd_pkg::phase_type phase_ff, phase_in;
   logic fin_ff, fin_in, rsp_valid_ff, rsp_valid_in;
   logic out_free, accept, fin, first_half;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (phase_ff != wspmd_pkg::PH_CONV) && out_free;
   assign accept     = req_valid && req_ready;
   assign fin        = req_final;
   assign first_half = stat.stereo && !stat.pos;
   assign rsp_valid  = rsp_valid_ff;

   // next state
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         wspmd_pkg::PH_RIFF: if (accept) begin
            if (stat.idx == 4'd3 && !stat.tag_next_riff)
               phase_in = fin ? wspmd_pkg::PH_RIFF : wspmd_pkg::PH_DRAIN;
            else if (stat.idx >= 4'd11)
               phase_in = fin ? wspmd_pkg::PH_RIFF :
                          (stat.tag_next_wave ? wspmd_pkg::PH_HDR : wspmd_pkg::PH_DRAIN);
         end
         wspmd_pkg::PH_HDR: if (accept) begin
            if (stat.idx < 4'd7)
               phase_in = fin ? wspmd_pkg::PH_RIFF : wspmd_pkg::PH_HDR;
            else if (stat.tag_fmt)
               phase_in = fin ? wspmd_pkg::PH_RIFF :
                          (stat.left_next_lt16 ? wspmd_pkg::PH_DRAIN : wspmd_pkg::PH_FMT);
            else if (stat.tag_data)
               phase_in = fin ? wspmd_pkg::PH_RIFF :
                          ((stat.hdr_err || stat.left_next_zero) ? wspmd_pkg::PH_DRAIN
                                                                 : wspmd_pkg::PH_DATA);
            else
               phase_in = fin ? wspmd_pkg::PH_RIFF :
                          (stat.left_next_zero ? wspmd_pkg::PH_HDR : wspmd_pkg::PH_SKIP);
         end
         wspmd_pkg::PH_FMT: if (accept) begin
            if (fin)
               phase_in = wspmd_pkg::PH_RIFF;
            else if (stat.idx >= 4'd15)
               phase_in = stat.left_zero ? wspmd_pkg::PH_HDR : wspmd_pkg::PH_SKIP;
         end
         wspmd_pkg::PH_SKIP: if (accept) begin
            if (fin)
               phase_in = wspmd_pkg::PH_RIFF;
            else if (stat.left_one)
               phase_in = wspmd_pkg::PH_HDR;
         end
         wspmd_pkg::PH_DATA: if (accept) begin
            if (stat.sample_done)
               phase_in = wspmd_pkg::PH_CONV;
            else if (fin)
               phase_in = wspmd_pkg::PH_RIFF;
         end
         wspmd_pkg::PH_CONV: begin
            if (first_half && !fin_ff)
               phase_in = wspmd_pkg::PH_DATA;
            else if (out_free) begin
               if (fin_ff)
                  phase_in = wspmd_pkg::PH_RIFF;
               else if (!first_half && stat.left_zero)
                  phase_in = wspmd_pkg::PH_DRAIN;
               else
                  phase_in = wspmd_pkg::PH_DATA;
            end
         end
         wspmd_pkg::PH_DRAIN: if (accept && fin) phase_in = wspmd_pkg::PH_RIFF;
         default: phase_in = wspmd_pkg::PH_RIFF;
      endcase
   end

   // commands
   always_comb begin
      cmd    = '0;
      fin_in = fin_ff;
      case (phase_ff)
         wspmd_pkg::PH_RIFF: if (accept) begin
            cmd.tag_shift = (stat.idx < 4'd4) || (stat.idx >= 4'd8);
            cmd.clear_all = fin;
            if ((stat.idx == 4'd3 && !stat.tag_next_riff) ||
                (stat.idx >= 4'd11 && !stat.tag_next_wave) ||
                (stat.idx < 4'd11 && fin)) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = wspmd_pkg::KIND_ERROR;
               cmd.out_err  = wspmd_pkg::ERR_MAGIC;
            end else if (stat.idx >= 4'd11) begin
               cmd.enter_hdr = 1'b1;
               cmd.out_load  = fin;
               cmd.out_kind  = wspmd_pkg::KIND_ERROR;
               cmd.out_err   = wspmd_pkg::ERR_MISSING;
            end else
               cmd.idx_inc = 1'b1;
         end
         wspmd_pkg::PH_HDR: if (accept) begin
            cmd.tag_shift = (stat.idx < 4'd4);
            cmd.left_hdr  = (stat.idx >= 4'd4);
            cmd.clear_all = fin;
            cmd.out_kind  = wspmd_pkg::KIND_ERROR;
            cmd.out_err   = wspmd_pkg::ERR_MISSING;
            if (stat.idx < 4'd7) begin
               cmd.idx_inc  = 1'b1;
               cmd.out_load = fin;
            end else begin
               cmd.idx_clr = 1'b1;
               if (stat.tag_fmt) begin
                  cmd.out_load   = stat.left_next_lt16 || fin;
                  cmd.out_err    = stat.left_next_lt16 ? wspmd_pkg::ERR_SHORT_FMT
                                                       : wspmd_pkg::ERR_TRUNC_FMT;
                  cmd.left_sub16 = 1'b1;
               end else if (stat.tag_data) begin
                  cmd.out_load = 1'b1;
                  if (stat.hdr_err)
                     cmd.out_err = stat.hdr_err_code;
                  else if (stat.left_next_zero) begin
                     cmd.out_kind = wspmd_pkg::KIND_INFO;
                     cmd.out_last = 1'b1;
                  end else if (fin)
                     cmd.out_err = wspmd_pkg::ERR_TRUNC_DAT;
                  else begin
                     cmd.out_kind   = wspmd_pkg::KIND_INFO;
                     cmd.gather_clr = 1'b1;
                     cmd.pos_clr    = 1'b1;
                  end
               end else begin
                  cmd.enter_hdr = stat.left_next_zero;
                  cmd.out_load  = fin;
               end
            end
         end
         wspmd_pkg::PH_FMT: if (accept) begin
            cmd.fmt_cap   = 1'b1;
            cmd.clear_all = fin;
            cmd.out_load  = fin;
            cmd.out_kind  = wspmd_pkg::KIND_ERROR;
            if (stat.idx >= 4'd15) begin
               cmd.fmt_seen_set = 1'b1;
               cmd.enter_hdr    = stat.left_zero;
               cmd.idx_clr      = 1'b1;
               cmd.out_err      = wspmd_pkg::ERR_MISSING;
            end else begin
               cmd.idx_inc = 1'b1;
               cmd.out_err = wspmd_pkg::ERR_TRUNC_FMT;
            end
         end
         wspmd_pkg::PH_SKIP: if (accept) begin
            cmd.left_dec  = 1'b1;
            cmd.enter_hdr = stat.left_one;
            cmd.clear_all = fin;
            cmd.out_load  = fin;
            cmd.out_kind  = wspmd_pkg::KIND_ERROR;
            cmd.out_err   = wspmd_pkg::ERR_MISSING;
         end
         wspmd_pkg::PH_DATA: if (accept) begin
            cmd.left_dec   = 1'b1;
            cmd.gather_put = 1'b1;
            cmd.idx_inc    = 1'b1;
            fin_in         = fin;
            if (!stat.sample_done && fin) begin
               cmd.clear_all = 1'b1;
               cmd.out_load  = 1'b1;
               cmd.out_kind  = wspmd_pkg::KIND_ERROR;
               cmd.out_err   = wspmd_pkg::ERR_TRUNC_DAT;
            end
         end
         wspmd_pkg::PH_CONV: begin
            if (first_half && !fin_ff) begin
               cmd.first_store = 1'b1;
               cmd.gather_clr  = 1'b1;
               cmd.idx_clr     = 1'b1;
            end else if (out_free) begin
               cmd.gather_clr = 1'b1;
               cmd.idx_clr    = 1'b1;
               cmd.pos_clr    = 1'b1;
               cmd.clear_all  = fin_ff;
               cmd.out_load   = 1'b1;
               if (!first_half && stat.left_zero) begin
                  cmd.out_kind = wspmd_pkg::KIND_SAMPLE;
                  cmd.out_last = 1'b1;
               end else if (fin_ff) begin
                  cmd.out_kind = wspmd_pkg::KIND_ERROR;
                  cmd.out_err  = wspmd_pkg::ERR_TRUNC_DAT;
               end else
                  cmd.out_kind = wspmd_pkg::KIND_SAMPLE;
            end
         end
         wspmd_pkg::PH_DRAIN: cmd.clear_all = accept && fin;
         default: ;
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= wspmd_pkg::PH_RIFF;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `WSPMD_ASSERT_SAME(a_load_free, clock, reset, cmd.out_load, out_free)
   `WSPMD_ASSERT_SAME(a_conv_stall, clock, reset, phase_ff == wspmd_pkg::PH_CONV, !req_ready)
   `WSPMD_ASSERT_NEXT(a_final_ends, clock, reset, accept && fin,
                      phase_ff == wspmd_pkg::PH_RIFF || phase_ff == wspmd_pkg::PH_CONV)
   `WSPMD_ASSERT_NEXT(a_conv_leaves, clock, reset,
                      phase_ff == wspmd_pkg::PH_CONV && out_free,
                      phase_ff != wspmd_pkg::PH_CONV)
endmodule
`default_nettype wire

/* rtl/wav_stream_parser_mono_downmix_core.sv */
`default_nettype none
// WAV stream parser with mono downmix. Feed the file one byte per request,
// flagging the last byte; results come back as stream info (once, at the data
// chunk header), one Q1.31 mono sample per frame, or an error. The byte that
// completes a source sample is followed by a conversion step, in which the
// float/PCM converter and the stereo averager run and no request is taken.
// The data size check against the frame size is folded into the header bytes
// and does not stall. Requests are also held off while a result waits and the
// result register is not free. After an error or the last sample, drop bytes
// until the flagged final byte, then start afresh.
module wav_stream_parser_mono_downmix_core (
   input wire logic    clock,
   input wire logic    reset,
   wspmd_req_if.sink   req_chan,
   wspmd_rsp_if.source rsp_chan
);
   wspmd_pkg::stat_type stat;
   wspmd_pkg::cmd_type  cmd;

   // controller: phase sequencing, handshakes and result timing
   wspmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_final (req_chan.final_byte),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: tag and length gathering, fmt capture, sample conversion
   wspmd_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .file_byte       (req_chan.file_byte),
      .cmd             (cmd),
      .stat            (stat),
      .result_kind     (rsp_chan.result_kind),
      .mono_sample     (rsp_chan.mono_sample),
      .rate_hz         (rsp_chan.rate_hz),
      .source_channels (rsp_chan.source_channels),
      .sample_bits     (rsp_chan.sample_bits),
      .error_code      (rsp_chan.error_code),
      .last_of_stream  (rsp_chan.last_of_stream)
   );
endmodule
`default_nettype wire

/* sim/tb_wav_stream_parser_mono_downmix_core.sv */
`default_nettype none
module tb_wav_stream_parser_mono_downmix_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int BYTE_TARGET = 1450;
   localparam int QUIET_FROM  = 500;    // no idling on either side in this window
   localparam int QUIET_TO    = 1300;
   localparam logic [31:0] TAG_RIFF = 32'h52494646;
   localparam logic [31:0] TAG_WAVE = 32'h57415645;
   localparam logic [31:0] TAG_FMT  = 32'h666D7420;
   localparam logic [31:0] TAG_DATA = 32'h64617461;
   localparam logic [31:0] TAG_LIST = 32'h4C495354;
   localparam logic [31:0] Q31_MAX  = 32'h7FFFFFFF;
   localparam logic [31:0] Q31_MIN  = 32'h80000000;
   localparam logic [15:0] FMT_PCM   = 16'd1;
   localparam logic [15:0] FMT_FLOAT = 16'd3;

   // ways to spoil a file
   typedef enum int {SPOIL_NONE, SPOIL_CUT, SPOIL_BYTE, SPOIL_FIELD} spoil_type;

   typedef struct {
      logic [7:0] fbyte;
      logic       fin;
   } file_request_type;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] smp;
      logic [31:0] rate;
      logic [1:0]  ch;
      logic [6:0]  bits;
      logic [3:0]  err;
      logic        last;
   } wav_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   error_count = 0;
   int   files_built = 0;
   int   samples_seen = 0;
   int   infos_seen = 0;
   int   errors_seen = 0;
   bit   req_fired = 1'b0;
   bit   stimulus_loaded = 1'b0;

   file_request_type pending_bytes[$];
   file_request_type file_buf[$];
   wav_result_type   expected_results[$];

   wspmd_req_if req_bus ();
   wspmd_rsp_if rsp_bus ();

   wav_stream_parser_mono_downmix_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus.sink),
      .rsp_chan(rsp_bus.source)
   );

   always #5 clock = ~clock;

   // Parser state mirrored by the predictor.
   wspmd_pkg::phase_type ps_phase;
   logic [31:0] ps_left;
   logic [31:0] ps_tag;
   logic [63:0] ps_gather;
   logic [15:0] ps_format;
   logic [15:0] ps_channels;
   logic [31:0] ps_rate;
   logic [15:0] ps_bits;
   logic        ps_fmt_seen;
   logic [31:0] ps_first;
   logic        ps_pos;
   logic [3:0]  ps_idx;

   function automatic void parser_clear();
      ps_phase = wspmd_pkg::PH_RIFF;
      ps_left = '0; ps_tag = '0; ps_gather = '0; ps_format = '0; ps_channels = '0;
      ps_rate = '0; ps_bits = '0; ps_fmt_seen = 1'b0; ps_first = '0; ps_pos = 1'b0;
      ps_idx = '0;
   endfunction

   function automatic void parser_enter_header();
      ps_phase = wspmd_pkg::PH_HDR;
      ps_left = '0;
      ps_tag = '0;
      ps_idx = '0;
   endfunction

   // End of a file or of a stream: clear now on the final byte, else drop bytes.
   function automatic void parser_finish(input logic fin);
      if (fin) parser_clear();
      else ps_phase = wspmd_pkg::PH_DRAIN;
   endfunction

   function automatic bit raise_error(input logic [3:0] code, input logic fin,
                                      output wav_result_type r);
      r = '{kind: wspmd_pkg::KIND_ERROR, smp: '0, rate: '0, ch: '0, bits: '0, err: code,
            last: 1'b0};
      parser_finish(fin);
      return 1'b1;
   endfunction

   function automatic logic [31:0] saturate_q31(input logic neg, input logic [63:0] m,
                                                input int sh, input logic big);
      logic [63:0] mag;
      if (!big && sh > 7 && m != 0) big = 1'b1;
      if (big) return neg ? Q31_MIN : Q31_MAX;
      if (sh >= 0) mag = (sh > 7) ? 64'd0 : (m << sh);
      else mag = (-sh >= 64) ? 64'd0 : (m >> (-sh));
      if (mag >= 64'h80000000) return neg ? Q31_MIN : Q31_MAX;
      return neg ? (32'd0 - mag[31:0]) : mag[31:0];
   endfunction

   function automatic logic [31:0] sample_to_q31();
      logic [63:0] g;
      logic [7:0]  e8;
      logic [10:0] e11;
      g = ps_gather;
      if (ps_format == FMT_FLOAT) begin
         if (ps_bits == 16'd32) begin
            e8 = g[30:23];
            if (e8 == 8'hFF) return (g[22:0] != 0) ? 32'd0 : (g[31] ? Q31_MIN : Q31_MAX);
            if (e8 == 8'h00) return saturate_q31(g[31], {41'd0, g[22:0]}, -118, 1'b0);
            return saturate_q31(g[31], {40'd0, 1'b1, g[22:0]}, int'(e8) - 119, e8 >= 8'd127);
         end
         e11 = g[62:52];
         if (e11 == 11'h7FF) return (g[51:0] != 0) ? 32'd0 : (g[63] ? Q31_MIN : Q31_MAX);
         if (e11 == 11'h000) return 32'd0;
         return saturate_q31(g[63], {11'd0, 1'b1, g[51:0]}, int'(e11) - 1044,
                             e11 >= 11'd1023);
      end
      case (ps_bits)
         16'd8:  return {g[7] ^ 1'b1, g[6:0], 24'd0};
         16'd16: return {g[15:0], 16'd0};
         16'd24: return {g[23:0], 8'd0};
         default: return g[31:0];
      endcase
   endfunction

   function automatic bit data_chunk_header(input logic fin, output wav_result_type r);
      logic [31:0] frame;
      if (!ps_fmt_seen) return raise_error(wspmd_pkg::ERR_MISSING, fin, r);
      if (ps_channels < 16'd1 || ps_channels > 16'd2)
         return raise_error(wspmd_pkg::ERR_CHANNELS, fin, r);
      if (ps_rate == 0) return raise_error(wspmd_pkg::ERR_ZERO_RATE, fin, r);
      if (ps_format != FMT_PCM && ps_format != FMT_FLOAT)
         return raise_error(wspmd_pkg::ERR_FORMAT, fin, r);
      if (ps_format == FMT_FLOAT && ps_bits != 16'd32 && ps_bits != 16'd64)
         return raise_error(wspmd_pkg::ERR_FLT_BITS, fin, r);
      if (ps_format == FMT_PCM && ps_bits != 16'd8 && ps_bits != 16'd16 &&
          ps_bits != 16'd24 && ps_bits != 16'd32)
         return raise_error(wspmd_pkg::ERR_PCM_BITS, fin, r);
      frame = (ps_bits / 8) * ps_channels;
      if (ps_left % frame != 0) return raise_error(wspmd_pkg::ERR_DATA_SIZE, fin, r);
      r = '{kind: wspmd_pkg::KIND_INFO, smp: '0, rate: ps_rate, ch: ps_channels[1:0],
            bits: ps_bits[6:0], err: '0, last: 1'b0};
      if (ps_left == 0) begin
         r.last = 1'b1;
         parser_finish(fin);
         return 1'b1;
      end
      if (fin) return raise_error(wspmd_pkg::ERR_TRUNC_DAT, fin, r);
      ps_phase = wspmd_pkg::PH_DATA;
      ps_gather = '0;
      ps_idx = '0;
      ps_pos = 1'b0;
      return 1'b1;
   endfunction

   // Advance the parser by one file byte; return 1 when a result is due.
   function automatic bit parse_file_byte(input logic [7:0] b, input logic fin,
                                          output wav_result_type r);
      logic [3:0]  idx;
      logic [31:0] v;
      logic [32:0] s;
      idx = ps_idx;
      r = '{default: '0};
      case (ps_phase)
         wspmd_pkg::PH_RIFF: begin
            if (idx < 4 || idx >= 8) ps_tag = {ps_tag[23:0], b};
            if (idx == 3 && ps_tag != TAG_RIFF)
               return raise_error(wspmd_pkg::ERR_MAGIC, fin, r);
            if (idx >= 11) begin
               if (ps_tag != TAG_WAVE) return raise_error(wspmd_pkg::ERR_MAGIC, fin, r);
               parser_enter_header();
               return fin ? raise_error(wspmd_pkg::ERR_MISSING, fin, r) : 1'b0;
            end
            ps_idx = idx + 1;
            return fin ? raise_error(wspmd_pkg::ERR_MAGIC, fin, r) : 1'b0;
         end
         wspmd_pkg::PH_HDR: begin
            if (idx < 4) ps_tag = {ps_tag[23:0], b};
            else ps_left = ps_left | (32'(b) << (8 * ((idx - 4) & 3)));
            if (idx < 7) begin
               ps_idx = idx + 1;
               return fin ? raise_error(wspmd_pkg::ERR_MISSING, fin, r) : 1'b0;
            end
            ps_idx = '0;
            if (ps_tag == TAG_FMT) begin
               if (ps_left < 16) return raise_error(wspmd_pkg::ERR_SHORT_FMT, fin, r);
               if (fin) return raise_error(wspmd_pkg::ERR_TRUNC_FMT, fin, r);
               ps_left = ps_left - 16;
               ps_phase = wspmd_pkg::PH_FMT;
               return 1'b0;
            end
            if (ps_tag == TAG_DATA) return data_chunk_header(fin, r);
            if (ps_left == 0) parser_enter_header();
            else ps_phase = wspmd_pkg::PH_SKIP;
            return fin ? raise_error(wspmd_pkg::ERR_MISSING, fin, r) : 1'b0;
         end
         wspmd_pkg::PH_FMT: begin
            case (idx)
               4'd0:  ps_format[7:0] = b;
               4'd1:  ps_format[15:8] = b;
               4'd2:  ps_channels[7:0] = b;
               4'd3:  ps_channels[15:8] = b;
               4'd4:  ps_rate = {24'd0, b};
               4'd5:  ps_rate[15:8] = b;
               4'd6:  ps_rate[23:16] = b;
               4'd7:  ps_rate[31:24] = b;
               4'd14: ps_bits[7:0] = b;
               4'd15: ps_bits[15:8] = b;
               default: ;
            endcase
            // low bytes overwrite the whole field, as a fresh capture
            if (idx == 4'd0) ps_format[15:8] = '0;
            if (idx == 4'd2) ps_channels[15:8] = '0;
            if (idx == 4'd14) ps_bits[15:8] = '0;
            if (idx >= 15) begin
               ps_fmt_seen = 1'b1;
               if (ps_left == 0) parser_enter_header();
               else begin
                  ps_phase = wspmd_pkg::PH_SKIP;
                  ps_idx = '0;
               end
               return fin ? raise_error(wspmd_pkg::ERR_MISSING, fin, r) : 1'b0;
            end
            ps_idx = idx + 1;
            return fin ? raise_error(wspmd_pkg::ERR_TRUNC_FMT, fin, r) : 1'b0;
         end
         wspmd_pkg::PH_SKIP: begin
            ps_left = ps_left - 1;
            if (ps_left == 0) parser_enter_header();
            return fin ? raise_error(wspmd_pkg::ERR_MISSING, fin, r) : 1'b0;
         end
         wspmd_pkg::PH_DATA: begin
            ps_left = ps_left - 1;
            ps_gather = ps_gather | (64'(b) << (8 * idx[2:0]));
            ps_idx = idx + 1;
            if (ps_idx < ps_bits / 8)
               return fin ? raise_error(wspmd_pkg::ERR_TRUNC_DAT, fin, r) : 1'b0;
            v = sample_to_q31();
            ps_gather = '0;
            ps_idx = '0;
            if (ps_channels == 16'd2 && !ps_pos) begin
               ps_first = v;
               ps_pos = 1'b1;
               return fin ? raise_error(wspmd_pkg::ERR_TRUNC_DAT, fin, r) : 1'b0;
            end
            if (ps_channels == 16'd2) begin
               // average in offset binary, then shift back
               s = {1'b0, ps_first ^ Q31_MIN} + {1'b0, v ^ Q31_MIN};
               v = s[32:1] ^ Q31_MIN;
            end
            ps_pos = 1'b0;
            r = '{kind: wspmd_pkg::KIND_SAMPLE, smp: v, rate: '0, ch: '0, bits: '0, err: '0,
                  last: 1'b0};
            if (ps_left == 0) begin
               r.last = 1'b1;
               parser_finish(fin);
               return 1'b1;
            end
            if (fin) return raise_error(wspmd_pkg::ERR_TRUNC_DAT, fin, r);
            return 1'b1;
         end
         default: begin
            if (fin) parser_clear();
            return 1'b0;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("MISMATCH cycle %0d: %s got 0x%0h, expected 0x%0h", cycle_count, what, got,
               want);
   endtask

   // ---------------------------------------------------------------- file builder
   function automatic void put8(input logic [7:0] v);
      file_buf.push_back('{fbyte: v, fin: 1'b0});
   endfunction

   function automatic void put16(input logic [15:0] v);
      put8(v[7:0]); put8(v[15:8]);
   endfunction

   function automatic void put32(input logic [31:0] v);
      put16(v[15:0]); put16(v[31:16]);
   endfunction

   function automatic void put_tag(input logic [31:0] t);
      put8(t[31:24]); put8(t[23:16]); put8(t[15:8]); put8(t[7:0]);
   endfunction

   // Random float word, mostly with exponents near the Q1.31 range.
   function automatic logic [63:0] random_float(input logic [15:0] bits);
      logic [63:0] w;
      w = {$urandom, $urandom};
      if (bits == 16'd32) begin
         w[63:32] = '0;
         if ($urandom_range(0, 3) != 0) w[30:23] = 8'($urandom_range(90, 130));
      end else if ($urandom_range(0, 3) != 0) begin
         w[62:52] = 11'($urandom_range(980, 1026));
      end
      return w;
   endfunction

   // Build one file and move it to the request queue, the last byte flagged.
   task automatic build_wav(input logic [15:0] fmt, input logic [15:0] chans,
                            input logic [31:0] rate, input logic [15:0] bits,
                            input int frames, input int fmt_extra, input int pre_chunk,
                            input int data_adjust, input spoil_type spoil,
                            input logic [63:0] pinned);
      int n;
      int bytes_per;
      logic [63:0] w;
      file_buf.delete();
      put_tag(TAG_RIFF);
      put32(32'($urandom));
      put_tag(TAG_WAVE);
      if (pre_chunk > 0) begin
         put_tag(TAG_LIST);
         put32(32'(pre_chunk - 1));
         for (int k = 0; k < pre_chunk - 1; k++) put8(8'($urandom));
      end
      put_tag(TAG_FMT);
      put32(32'(16 + fmt_extra));
      put16(fmt);
      put16(chans);
      put32(rate);
      put32(32'($urandom));
      put16(16'($urandom));
      put16(bits);
      for (int k = 0; k < fmt_extra; k++) put8(8'($urandom));
      bytes_per = (bits >= 8 && bits <= 64) ? bits / 8 : 2;
      put_tag(TAG_DATA);
      n = frames * bytes_per * ((chans == 2) ? 2 : 1) + data_adjust;
      if (n < 0) n = 0;
      put32(32'(n));
      for (int k = 0; k < n; k += bytes_per) begin
         w = (fmt == FMT_FLOAT) ? random_float(bits) : {$urandom, $urandom};
         if (k == 0 && pinned != '1) w = pinned;
         for (int j = 0; j < bytes_per && k + j < n; j++) put8(w[8 * j +: 8]);
      end
      case (spoil)
         SPOIL_CUT: begin
            n = $urandom_range(0, file_buf.size() - 1);
            while (file_buf.size() > n + 1) void'(file_buf.pop_back());
         end
         SPOIL_BYTE: begin
            n = $urandom_range(0, file_buf.size() - 1);
            file_buf[n].fbyte = 8'($urandom);
         end
         default: ;
      endcase
      file_buf[file_buf.size() - 1].fin = 1'b1;
      foreach (file_buf[k]) pending_bytes.push_back(file_buf[k]);
      files_built++;
   endtask

   // Random well-formed header values, with a bad field on request; else some files cut or with a random byte.
   task automatic random_file(input bit spoil_field);
      logic [15:0] fmt, chans, bits;
      logic [31:0] rate;
      int frames;
      spoil_type spoil;
      fmt = ($urandom_range(0, 2) == 0) ? FMT_FLOAT : FMT_PCM;
      chans = 16'($urandom_range(1, 2));
      bits = (fmt == FMT_FLOAT) ? (($urandom_range(0, 1) != 0) ? 16'd32 : 16'd64)
                                : 16'(8 * $urandom_range(1, 4));
      rate = ($urandom_range(0, 1) != 0) ? 32'd48000 : 32'($urandom_range(1, 32'hFFFFFFFF));
      frames = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      spoil = spoil_type'($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0);
      if (spoil_field) begin
         spoil = SPOIL_NONE;
         case ($urandom_range(0, 5))
            0: chans = 16'($urandom_range(0, 1) ? 0 : $urandom_range(3, 65535));
            1: rate = '0;
            2: fmt = 16'($urandom_range(0, 1) ? 2 : $urandom_range(4, 65535));
            3: bits = 16'($urandom_range(0, 70));
            4: frames = -1;
            default: chans = 16'h0102;
         endcase
      end
      build_wav(fmt, chans, rate, bits, frames,
                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0,
                ($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0,
                (frames == -1) ? $urandom_range(1, 3) + 2 : 0, spoil, '1);
   endtask

   // ---------------------------------------------------------------- stimulus
   initial begin
      // Directed: each PCM width at one extreme, float specials, stereo, empty data and a bad data size.
      build_wav(FMT_PCM, 16'd1, 32'hFFFFFFFF, 16'd8, 1, 0, 0, 0, SPOIL_NONE, 64'h00);
      build_wav(FMT_PCM, 16'd2, 32'd1, 16'd16, 1, 0, 0, 0, SPOIL_NONE, 64'h8000);
      build_wav(FMT_PCM, 16'd1, 32'd8000, 16'd24, 1, 2, 1, 0, SPOIL_NONE, 64'h7FFFFF);
      build_wav(FMT_PCM, 16'd2, 32'd8000, 16'd32, 1, 0, 0, 0, SPOIL_NONE, 64'h80000000);
      build_wav(FMT_FLOAT, 16'd1, 32'd44100, 16'd32, 1, 0, 0, 0, SPOIL_NONE, 64'h7FC00000);
      build_wav(FMT_FLOAT, 16'd1, 32'd44100, 16'd32, 1, 0, 0, 0, SPOIL_NONE, 64'hFF800000);
      build_wav(FMT_FLOAT, 16'd1, 32'd44100, 16'd32, 1, 0, 0, 0, SPOIL_NONE, 64'h00000001);
      build_wav(FMT_FLOAT, 16'd1, 32'd44100, 16'd32, 1, 0, 0, 0, SPOIL_NONE, 64'hBF800000);
      build_wav(FMT_FLOAT, 16'd2, 32'd96000, 16'd64, 1, 0, 0, 0, SPOIL_NONE,
                64'h3FEFFFFFFFFFFFFF);
      build_wav(FMT_FLOAT, 16'd1, 32'd96000, 16'd64, 1, 0, 0, 0, SPOIL_NONE,
                64'hFFF8000000000000);
      build_wav(FMT_PCM, 16'd1, 32'd16000, 16'd16, 0, 0, 0, 0, SPOIL_NONE, '1);
      build_wav(FMT_PCM, 16'd1, 32'd16000, 16'd16, 2, 0, 0, 1, SPOIL_NONE, '1);
      // Bad magic, and a fmt chunk shorter than 16 bytes.
      pending_bytes.push_back('{fbyte: "R", fin: 1'b0});
      pending_bytes.push_back('{fbyte: "X", fin: 1'b0});
      pending_bytes.push_back('{fbyte: 8'hFF, fin: 1'b1});
      file_buf.delete();
      put_tag(TAG_RIFF); put32('0); put_tag(TAG_WAVE); put_tag(TAG_FMT); put32(32'd15);
      file_buf[file_buf.size() - 1].fin = 1'b1;
      foreach (file_buf[k]) pending_bytes.push_back(file_buf[k]);
      // Random: mostly valid files with random content, the rest spoilt.
      while (pending_bytes.size() < BYTE_TARGET) random_file($urandom_range(0, 5) == 0);
      stimulus_loaded = 1'b1;
   end

   // ---------------------------------------------------------------- reset and drive
   initial begin
      req_bus.valid = 1'b0;
      req_bus.file_byte = '0;
      req_bus.final_byte = 1'b0;
      rsp_bus.ready = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   function automatic bit side_active();
      return (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) ||
             $urandom_range(0, 99) >= 31;
   endfunction

   // Driver: offer the next request, or hold the current one until taken.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (!req_bus.valid || req_fired) begin
            if (stimulus_loaded && pending_bytes.size() > 0 && side_active()) begin
               req_bus.valid <= 1'b1;
               req_bus.file_byte <= pending_bytes[0].fbyte;
               req_bus.final_byte <= pending_bytes[0].fin;
               void'(pending_bytes.pop_front());
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         rsp_bus.ready <= side_active();
      end
   end

   // Monitor: predict on each accepted request, check each accepted result.
   always @(posedge clock) begin
      wav_result_type predicted;
      wav_result_type want;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         parser_clear();
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            if (parse_file_byte(req_bus.file_byte, req_bus.final_byte, predicted))
               expected_results.push_back(predicted);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result, kind", rsp_bus.result_kind, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.result_kind != want.kind)
                  report_mismatch("result_kind", rsp_bus.result_kind, want.kind);
               if (rsp_bus.mono_sample != want.smp)
                  report_mismatch("mono_sample", rsp_bus.mono_sample, want.smp);
               if (rsp_bus.rate_hz != want.rate)
                  report_mismatch("rate_hz", rsp_bus.rate_hz, want.rate);
               if (rsp_bus.source_channels != want.ch)
                  report_mismatch("source_channels", rsp_bus.source_channels, want.ch);
               if (rsp_bus.sample_bits != want.bits)
                  report_mismatch("sample_bits", rsp_bus.sample_bits, want.bits);
               if (rsp_bus.error_code != want.err)
                  report_mismatch("error_code", rsp_bus.error_code, want.err);
               if (rsp_bus.last_of_stream != want.last)
                  report_mismatch("last_of_stream", rsp_bus.last_of_stream, want.last);
               case (want.kind)
                  wspmd_pkg::KIND_SAMPLE: samples_seen++;
                  wspmd_pkg::KIND_INFO:   infos_seen++;
                  default:                errors_seen++;
               endcase
            end
         end
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- end of run
   initial begin
      wait (stimulus_loaded);
      @(posedge clock);
      while (pending_bytes.size() > 0 || req_bus.valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      $display("%0d files streamed: %0d samples, %0d stream infos, %0d errors checked",
               files_built, samples_seen, infos_seen, errors_seen);
      $display("PCM 8/16/24/32, float32/64, mono and stereo, spoilt headers and cut files");
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire
